[design/uniform_lbp_cell_histogram_defines.svh]
// Assertion macros shared by the uniform LBP histogram RTL.
// Plain text macros only; no dependencies.
`ifndef UNIFORM_LBP_CELL_HISTOGRAM_DEFINES_SVH
`define UNIFORM_LBP_CELL_HISTOGRAM_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ULBP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ULBP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/ulbp_pkg.sv]
// Shared types, constants and the uniform-bin lookup for the LBP histogram block.
// No dependencies; every design module imports this package.
package ulbp_pkg;

    localparam int DEF_MAX_WIDTH = 1024;
    localparam int DEF_GRID_X    = 2;
    localparam int DEF_GRID_Y    = 2;

    localparam int BIN_COUNT      = 59;
    localparam int NONUNIFORM_BIN = 58;
    localparam int MAX_HEIGHT     = 1024;
    localparam int MIN_DIM        = 3;

    localparam int PIXEL_W   = 8;
    localparam int LINE_DW   = 2 * PIXEL_W;
    localparam int BIN_W     = 6;
    localparam int COUNT_W   = 18;
    localparam int ROW_W     = 10;
    localparam int EXT_W     = 13;
    localparam int IMG_W     = 11;
    localparam int CELL_SZ_W = 9;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [IMG_W-1:0]     RST_IMAGE_WIDTH  = IMG_W'(64);
    localparam logic [IMG_W-1:0]     RST_IMAGE_HEIGHT = IMG_W'(64);
    localparam logic [CELL_SZ_W-1:0] RST_CELL_WIDTH   = CELL_SZ_W'(31);
    localparam logic [CELL_SZ_W-1:0] RST_CELL_HEIGHT  = CELL_SZ_W'(31);

    typedef enum logic [1:0] {
        REQ_PIXEL = 2'd0,
        REQ_READ  = 2'd1,
        REQ_FRAME = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_CELL_WIDTH   = 2'd2,
        REG_CELL_HEIGHT  = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [IMG_W-1:0]     image_width;
        logic [IMG_W-1:0]     image_height;
        logic [CELL_SZ_W-1:0] cell_width;
        logic [CELL_SZ_W-1:0] cell_height;
    } cfg_t;

    typedef logic [BIN_W-1:0] bin_table_t [256];

    // At most two circular 0/1 transitions around the eight neighbours.
    function automatic logic is_uniform(logic [7:0] c);
        logic [7:0] rot;
        logic [7:0] diff;
        int         n;
        rot  = {c[6:0], c[7]};
        diff = c ^ rot;
        n    = 0;
        for (int i = 0; i < 8; i++) begin
            n = n + int'(diff[i]);
        end
        return (n <= 2);
    endfunction

    // Uniform codes are numbered in increasing code order; the rest share one bin.
    function automatic bin_table_t build_bin_table();
        bin_table_t tbl;
        int         k;
        k = 0;
        for (int c = 0; c < 256; c++) begin
            if (is_uniform(8'(c))) begin
                tbl[c] = BIN_W'(k);
                k      = k + 1;
            end else begin
                tbl[c] = BIN_W'(NONUNIFORM_BIN);
            end
        end
        return tbl;
    endfunction

    localparam bin_table_t UNIFORM_BIN_TABLE = build_bin_table();

endpackage

[design/ulbp_cfg_regs.sv]
// APB-style configuration registers: image size and grid cell size.
// Depends on ulbp_pkg for the register map and the cfg_t bundle.
module ulbp_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ulbp_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [ulbp_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ulbp_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output ulbp_pkg::cfg_t                 cfg
);
    import ulbp_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width  <= RST_IMAGE_WIDTH;
            cfg_reg.image_height <= RST_IMAGE_HEIGHT;
            cfg_reg.cell_width   <= RST_CELL_WIDTH;
            cfg_reg.cell_height  <= RST_CELL_HEIGHT;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_IMAGE_WIDTH:  cfg_reg.image_width  <= pwdata[IMG_W-1:0];
                REG_IMAGE_HEIGHT: cfg_reg.image_height <= pwdata[IMG_W-1:0];
                REG_CELL_WIDTH:   cfg_reg.cell_width   <= pwdata[CELL_SZ_W-1:0];
                REG_CELL_HEIGHT:  cfg_reg.cell_height  <= pwdata[CELL_SZ_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(cfg_reg.image_width);
            REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(cfg_reg.image_height);
            REG_CELL_WIDTH:   prdata = APB_DATA_W'(cfg_reg.cell_width);
            REG_CELL_HEIGHT:  prdata = APB_DATA_W'(cfg_reg.cell_height);
        endcase
    end

endmodule

[design/ulbp_line_store.sv]
// Two line stores held as one memory word per column: {two rows above, row above}.
// Depends on ulbp_pkg; unwritten columns read as zero through a fill count.
module ulbp_line_store #(
    parameter int MAX_WIDTH = ulbp_pkg::DEF_MAX_WIDTH,
    localparam int COL_W    = $clog2(MAX_WIDTH)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         rd_en,
    input  logic [COL_W-1:0]             rd_addr,
    input  logic                         wr_en,
    input  logic [COL_W-1:0]             wr_addr,
    input  logic [ulbp_pkg::LINE_DW-1:0] wr_data,
    output logic [ulbp_pkg::LINE_DW-1:0] rd_data
);
    import ulbp_pkg::*;

    localparam int CNT_W = $clog2(MAX_WIDTH + 1);

    logic [LINE_DW-1:0] line_ram [MAX_WIDTH];
    logic [LINE_DW-1:0] rd_data_reg;
    logic [CNT_W-1:0]   fill_reg;
    logic [CNT_W-1:0]   fill_next;

    assign rd_data = rd_data_reg;

    // Columns are written strictly in order from zero, so the written set is a prefix.
    always_comb
    begin
        fill_next = fill_reg;
        if (wr_en && (CNT_W'(wr_addr) == fill_reg))
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            line_ram[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            priority if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else if (CNT_W'(rd_addr) >= fill_reg)
            begin
                rd_data_reg <= '0;
            end
            else
            begin
                rd_data_reg <= line_ram[rd_addr];
            end
        end
    end

endmodule

[design/ulbp_code_unit.sv]
// 3x3 window registers, eight-neighbour comparison code and uniform-bin lookup.
// Depends on ulbp_pkg for the bin table.
module ulbp_code_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         shift_en,
    input  logic [ulbp_pkg::PIXEL_W-1:0] pixel,
    input  logic [ulbp_pkg::PIXEL_W-1:0] top,
    input  logic [ulbp_pkg::PIXEL_W-1:0] mid,
    output logic [7:0]                   code,
    output logic [ulbp_pkg::BIN_W-1:0]   bin
);
    import ulbp_pkg::*;

    // 0,1: top row; 2,3: middle row; 4,5: bottom row; odd index is the newer column
    logic [PIXEL_W-1:0] win_reg [6];
    logic [PIXEL_W-1:0] ctr;

    assign ctr = win_reg[3];

    always_comb
    begin
        code = {win_reg[0] >= ctr, win_reg[1] >= ctr, top >= ctr, mid >= ctr,
                pixel >= ctr, win_reg[5] >= ctr, win_reg[4] >= ctr, win_reg[2] >= ctr};
        bin  = UNIFORM_BIN_TABLE[code];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (shift_en)
        begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= top;
            win_reg[2] <= win_reg[3];
            win_reg[3] <= mid;
            win_reg[4] <= win_reg[5];
            win_reg[5] <= pixel;
        end
    end

endmodule

[design/ulbp_hist_store.sv]
// Histogram count memory, one read and one write port, with per-entry valid bits.
// Depends on ulbp_pkg; a write forwards to a read of the same entry in that cycle.
module ulbp_hist_store #(
    parameter int GRID_X       = ulbp_pkg::DEF_GRID_X,
    parameter int GRID_Y       = ulbp_pkg::DEF_GRID_Y,
    localparam int HIST_DEPTH  = GRID_X * GRID_Y * ulbp_pkg::BIN_COUNT,
    localparam int HIST_AW     = $clog2(HIST_DEPTH)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         rd_en,
    input  logic [HIST_AW-1:0]           rd_addr,
    input  logic                         wr_en,
    input  logic [HIST_AW-1:0]           wr_addr,
    input  logic [ulbp_pkg::COUNT_W-1:0] wr_data,
    output logic [ulbp_pkg::COUNT_W-1:0] rd_data
);
    import ulbp_pkg::*;

    logic [COUNT_W-1:0]    hist_ram [HIST_DEPTH];
    logic [COUNT_W-1:0]    rd_data_reg;
    logic [HIST_DEPTH-1:0] valid_reg;

    assign rd_data = rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            hist_ram[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            priority if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else if (!valid_reg[rd_addr])
            begin
                rd_data_reg <= '0;
            end
            else
            begin
                rd_data_reg <= hist_ram[rd_addr];
            end
        end
    end

endmodule

[design/uniform_lbp_cell_histogram.sv]
// Uniform LBP 8,1 cell histogram over a raster pixel stream; uses ulbp_pkg and ulbp_* units.
// Path: an accepted item reaches its result through the input, histogram read and result
// registers. Throughput: one item per cycle while no result waits on result_stall, held by
// the read-modify-write of the histogram memory, which forwards each write to the next read.
// Reset: default configuration, positions, window and line fill count clear, and every
// histogram bin reads zero through its valid bit, so the block takes items at once.
`include "uniform_lbp_cell_histogram_defines.svh"

module uniform_lbp_cell_histogram #(
    parameter int MAX_WIDTH = ulbp_pkg::DEF_MAX_WIDTH,
    parameter int GRID_X    = ulbp_pkg::DEF_GRID_X,
    parameter int GRID_Y    = ulbp_pkg::DEF_GRID_Y
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ulbp_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [ulbp_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ulbp_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  logic [1:0]                      req_type,
    input  logic [ulbp_pkg::PIXEL_W-1:0]    pixel_value,
    input  logic [1:0]                      cell_select,
    input  logic [ulbp_pkg::BIN_W-1:0]      bin_select,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic                            code_valid,
    output logic [7:0]                      lbp_code,
    output logic [ulbp_pkg::BIN_W-1:0]      uniform_bin,
    output logic [ulbp_pkg::COUNT_W-1:0]    bin_count
);
    import ulbp_pkg::*;

    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int CELLS      = GRID_X * GRID_Y;
    localparam int CELL_W     = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int HIST_DEPTH = CELLS * BIN_COUNT;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int CX_W       = $clog2(GRID_X + 1);
    localparam int CY_W       = $clog2(GRID_Y + 1);

    cfg_t cfg;

    // ---------------- position state and input stage ----------------
    logic               advance;
    logic               accept;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [EXT_W-1:0]   w_ext, h_ext, col_ext, row_ext, dx, dy, cw_ext, ch_ext;
    logic               window_ok, in_x, in_y;
    logic [CX_W-1:0]    cx_cnt;
    logic [CY_W-1:0]    cy_cnt;
    logic [CELL_W-1:0]  cell_idx;
    logic               read_ok;
    logic [HIST_AW-1:0] read_idx;

    // stage 1 registers
    logic               s1_valid_reg;
    logic               s1_pixel_reg, s1_read_reg;
    logic               s1_window_ok_reg, s1_count_ok_reg, s1_read_ok_reg;
    logic [CELL_W-1:0]  s1_cell_reg;
    logic [HIST_AW-1:0] s1_read_idx_reg;
    logic [PIXEL_W-1:0] s1_px_reg;
    logic [COL_W-1:0]   s1_col_reg;

    // stage 1 logic
    logic [LINE_DW-1:0] line_rd_data;
    logic               line_wr_en;
    logic [7:0]         code1;
    logic [BIN_W-1:0]   bin1;
    logic               code_valid1, inc1, clr1;
    logic               h_rd_en;
    logic [HIST_AW-1:0] h_rd_addr;

    // stage 2 registers
    logic               s2_valid_reg;
    logic               s2_inc_reg, s2_clr_reg, s2_code_valid_reg;
    logic [HIST_AW-1:0] s2_addr_reg;
    logic [7:0]         s2_code_reg;
    logic [BIN_W-1:0]   s2_bin_reg;

    // stage 2 logic
    logic [COUNT_W-1:0] h_rd_data;
    logic               h_wr_en;
    logic [COUNT_W-1:0] h_wr_data;

    // result register
    logic               result_valid_reg;
    logic               code_valid_reg;
    logic [7:0]         lbp_code_reg;
    logic [BIN_W-1:0]   uniform_bin_reg;
    logic [COUNT_W-1:0] bin_count_reg;

    ulbp_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The whole pipeline holds only while a finished result waits downstream.
    assign advance    = !(result_valid_reg && result_stall);
    assign item_stall = !advance;
    assign accept     = item_valid && advance;

    always_comb
    begin
        w_ext = EXT_W'(cfg.image_width);
        priority if (w_ext < EXT_W'(MIN_DIM))
            w_ext = EXT_W'(MIN_DIM);
        else if (w_ext > EXT_W'(MAX_WIDTH))
            w_ext = EXT_W'(MAX_WIDTH);

        h_ext = EXT_W'(cfg.image_height);
        priority if (h_ext < EXT_W'(MIN_DIM))
            h_ext = EXT_W'(MIN_DIM);
        else if (h_ext > EXT_W'(MAX_HEIGHT))
            h_ext = EXT_W'(MAX_HEIGHT);
    end

    assign col_ext = EXT_W'(col_reg);
    assign row_ext = EXT_W'(row_reg);
    assign cw_ext  = EXT_W'(cfg.cell_width);
    assign ch_ext  = EXT_W'(cfg.cell_height);
    assign dx      = col_ext - EXT_W'(2);
    assign dy      = row_ext - EXT_W'(2);

    assign window_ok = (row_ext >= EXT_W'(2)) && (col_ext >= EXT_W'(2)) &&
                       (row_ext < h_ext) && (col_ext < w_ext);

    // Cell index as a count of crossed cell boundaries; a zero cell size crosses them all.
    always_comb
    begin
        cx_cnt = '0;
        for (int k = 1; k <= GRID_X; k++)
        begin
            if (dx >= EXT_W'(k) * cw_ext)
                cx_cnt = cx_cnt + CX_W'(1);
        end
        cy_cnt = '0;
        for (int k = 1; k <= GRID_Y; k++)
        begin
            if (dy >= EXT_W'(k) * ch_ext)
                cy_cnt = cy_cnt + CY_W'(1);
        end
    end

    assign in_x     = (cx_cnt != CX_W'(GRID_X));
    assign in_y     = (cy_cnt != CY_W'(GRID_Y));
    assign cell_idx = CELL_W'(int'(cy_cnt) * GRID_X + int'(cx_cnt));

    assign read_ok  = (int'(cell_select) < CELLS) && (int'(bin_select) < BIN_COUNT);
    assign read_idx = HIST_AW'(int'(cell_select) * BIN_COUNT + int'(bin_select));

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            unique case (req_t'(req_type))
                REQ_PIXEL:
                begin
                    if (col_ext + EXT_W'(1) >= w_ext)
                    begin
                        col_next = '0;
                        row_next = (row_ext + EXT_W'(1) >= h_ext) ? '0 : row_reg + ROW_W'(1);
                    end
                    else
                    begin
                        col_next = COL_W'(col_ext + EXT_W'(1));
                        row_next = (row_ext >= h_ext) ? '0 : row_reg;
                    end
                end
                REQ_FRAME:
                begin
                    col_next = '0;
                    row_next = '0;
                end
                REQ_READ:
                begin
                    col_next = col_reg;
                    row_next = row_reg;
                end
                default:
                begin
                    col_next = col_reg;
                    row_next = row_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (advance)
                s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg     <= (req_type == REQ_PIXEL);
            s1_read_reg      <= (req_type == REQ_READ);
            s1_window_ok_reg <= window_ok;
            s1_count_ok_reg  <= window_ok && in_x && in_y;
            s1_cell_reg      <= cell_idx;
            s1_read_ok_reg   <= read_ok;
            s1_read_idx_reg  <= read_idx;
            s1_px_reg        <= pixel_value;
            s1_col_reg       <= col_reg;
        end
    end

    // ---------------- stage 1: window, code, histogram read ----------------
    assign line_wr_en = advance && s1_valid_reg && s1_pixel_reg;

    ulbp_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept && (req_type == REQ_PIXEL)),
        .rd_addr (col_reg),
        .wr_en   (line_wr_en),
        .wr_addr (s1_col_reg),
        .wr_data ({line_rd_data[PIXEL_W-1:0], s1_px_reg}),
        .rd_data (line_rd_data)
    );

    ulbp_code_unit u_code (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (line_wr_en),
        .pixel    (s1_px_reg),
        .top      (line_rd_data[LINE_DW-1:PIXEL_W]),
        .mid      (line_rd_data[PIXEL_W-1:0]),
        .code     (code1),
        .bin      (bin1)
    );

    assign code_valid1 = s1_pixel_reg && s1_window_ok_reg;
    assign inc1        = s1_pixel_reg && s1_count_ok_reg;
    assign clr1        = s1_read_reg && s1_read_ok_reg;
    assign h_rd_en     = advance && s1_valid_reg && (inc1 || clr1);
    assign h_rd_addr   = inc1 ? HIST_AW'(int'(s1_cell_reg) * BIN_COUNT + int'(bin1))
                              : s1_read_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            s2_inc_reg        <= inc1;
            s2_clr_reg        <= clr1;
            s2_addr_reg       <= h_rd_addr;
            s2_code_valid_reg <= code_valid1;
            s2_code_reg       <= code_valid1 ? code1 : 8'd0;
            s2_bin_reg        <= code_valid1 ? bin1 : '0;
        end
    end

    // ---------------- stage 2: count update and result ----------------
    assign h_wr_en   = advance && s2_valid_reg && (s2_inc_reg || s2_clr_reg);
    assign h_wr_data = s2_clr_reg ? '0
                     : ((h_rd_data == COUNT_MAX) ? COUNT_MAX : h_rd_data + COUNT_W'(1));

    ulbp_hist_store #(
        .GRID_X (GRID_X),
        .GRID_Y (GRID_Y)
    ) u_hist (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (h_rd_en),
        .rd_addr (h_rd_addr),
        .wr_en   (h_wr_en),
        .wr_addr (s2_addr_reg),
        .wr_data (h_wr_data),
        .rd_data (h_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s2_valid_reg)
        begin
            code_valid_reg  <= s2_code_valid_reg;
            lbp_code_reg    <= s2_code_reg;
            uniform_bin_reg <= s2_bin_reg;
            bin_count_reg   <= s2_clr_reg ? h_rd_data : '0;
        end
    end

    assign result_valid = result_valid_reg;
    assign code_valid   = code_valid_reg;
    assign lbp_code     = lbp_code_reg;
    assign uniform_bin  = uniform_bin_reg;
    assign bin_count    = bin_count_reg;

    // ---------------- assertions ----------------
    `ULBP_ASSERT_NEXT(a_result_follows_stage2, clk, rst_n, advance && s2_valid_reg, result_valid_reg, "item in stage 2 did not reach the result register")
    `ULBP_ASSERT_NOW(a_pixel_result_no_count, clk, rst_n, result_valid_reg && code_valid_reg, bin_count_reg == '0, "pixel result carries a bin count")
    `ULBP_ASSERT_NOW(a_column_in_range, clk, rst_n, 1'b1, col_ext < EXT_W'(MAX_WIDTH), "column position beyond the line store")

endmodule
